/* hdl/mfr_pkg.sv */
// ----------------------------------------------------------------------------
// mfr_pkg: shared types and constants of the meter frame receiver
// Frame layout constants, the checksum seed, the register indexes and the
// parsed frame record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam logic [7:0] RD_CMD      = 8'h58;
    localparam logic [7:0] HDR_BYTE    = 8'h55;
    localparam int         FRAME_LEN   = 23;
    localparam int         BODY_LEN    = FRAME_LEN - 1;
    localparam int         IDX_W       = $clog2(FRAME_LEN);
    localparam int         QUEUE_DEPTH = 2;

    localparam logic [31:0] CNT_WRAP_STEP = 32'h0100_0000;
    localparam logic [31:0] CNT_HIGH_MASK = 32'hFF00_0000;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELTA_MODE     = 4'd1;
    localparam int CFG_DATA_W = 8;

    localparam int OUT_DATA_W = 152;

    // One parsed frame with a good checksum; the count is still raw.
    typedef struct packed {
        logic [7:0]         status_byte;
        logic [15:0]        freq_period;
        logic [23:0]        raw_count;
        logic signed [23:0] active_power;
        logic [23:0]        fast_current_rms;
        logic [23:0]        voltage_rms;
        logic [23:0]        current_rms;
    } mfr_frame_t;

    // Status of the back end, watched by the top level's checks.
    typedef struct packed {
        logic        pop;
        logic        total_update;
        logic [31:0] last_total;
    } mfr_back_stat_t;

    // Status of the queue.
    typedef struct packed {
        logic full;
        logic empty;
        logic push;
    } mfr_queue_stat_t;

endpackage

/* hdl/mfr_front.sv */
// ----------------------------------------------------------------------------
// mfr_front: byte hunter and frame collector
// Hunts for the header, stores the frame body, checks the checksum and hands
// each good frame to the queue as one record.
// ----------------------------------------------------------------------------
module mfr_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         rx_byte,
    input  logic [1:0]         device_address,
    input  logic               queue_full,
    output logic               frame_push,
    output mfr_pkg::mfr_frame_t frame_rec
);
    import mfr_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       body_reg [BODY_LEN];
    logic             at_check;
    logic             take;
    logic [7:0]       expect_sum;

    assign at_check   = (idx_reg == IDX_W'(BODY_LEN));
    // Only the checksum word can be held back, and only by a full queue.
    assign byte_ready = !(at_check && queue_full);
    assign take       = byte_valid && byte_ready;
    assign expect_sum = ~((RD_CMD | {6'd0, device_address}) + sum_reg);
    assign frame_push = take && at_check && (expect_sum == rx_byte);

    always_comb begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (take) begin
            if (idx_reg == '0) begin
                if (rx_byte == HDR_BYTE) begin
                    idx_next = IDX_W'(1);
                    sum_next = rx_byte;
                end
            end else if (at_check) begin
                idx_next = '0;
                sum_next = '0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
                sum_next = sum_reg + rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            sum_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !at_check && (idx_reg != '0)) begin
            body_reg[idx_reg] <= rx_byte;
        end
    end

    always_comb begin
        frame_rec.current_rms      = {body_reg[3], body_reg[2], body_reg[1]};
        frame_rec.voltage_rms      = {body_reg[6], body_reg[5], body_reg[4]};
        frame_rec.fast_current_rms = {body_reg[9], body_reg[8], body_reg[7]};
        frame_rec.active_power     = {body_reg[12], body_reg[11], body_reg[10]};
        frame_rec.raw_count        = {body_reg[15], body_reg[14], body_reg[13]};
        frame_rec.freq_period      = {body_reg[17], body_reg[16]};
        frame_rec.status_byte      = body_reg[19];
    end

endmodule

/* hdl/mfr_queue.sv */
// ----------------------------------------------------------------------------
// mfr_queue: short frame queue
// A small first-in first-out store of parsed frames between front and back.
// ----------------------------------------------------------------------------
module mfr_queue #(
    parameter int QueueDepth = mfr_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mfr_pkg::mfr_frame_t     push_data,
    input  logic                    pop,
    output mfr_pkg::mfr_frame_t     pop_data,
    output mfr_pkg::mfr_queue_stat_t stat
);
    import mfr_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    mfr_frame_t      mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            do_push, do_pop;

    assign stat.full  = (cnt_reg == CntW'(QueueDepth));
    assign stat.empty = (cnt_reg == '0);
    assign stat.push  = do_push;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                   : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                   : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CntW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/mfr_back.sv */
// ----------------------------------------------------------------------------
// mfr_back: count extension and output register
// Extends the pulse count in total mode and holds the result word until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module mfr_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     queue_empty,
    input  mfr_pkg::mfr_frame_t      frame_rec,
    output logic                     frame_pop,
    input  logic                     delta_mode,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [mfr_pkg::OUT_DATA_W-1:0] m_tdata,
    output mfr_pkg::mfr_back_stat_t  stat
);
    import mfr_pkg::*;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [31:0]           last_total_reg, last_total_next;
    logic [31:0]           joined;
    logic [31:0]           count;

    assign frame_pop = !queue_empty && (!out_valid_reg || m_tready);

    always_comb begin
        joined = (last_total_reg & CNT_HIGH_MASK) | {8'd0, frame_rec.raw_count};
        if (joined < last_total_reg) begin
            last_total_next = joined + CNT_WRAP_STEP;
        end else begin
            last_total_next = joined;
        end
        count = delta_mode ? {8'd0, frame_rec.raw_count} : last_total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            last_total_reg <= '0;
        end else begin
            if (frame_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (frame_pop && !delta_mode) begin
                last_total_reg <= last_total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_pop) begin
            out_data_reg <= {frame_rec.status_byte, frame_rec.freq_period, count,
                             frame_rec.active_power, frame_rec.fast_current_rms,
                             frame_rec.voltage_rms, frame_rec.current_rms};
        end
    end

    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = out_data_reg;
    assign stat.pop           = frame_pop;
    assign stat.total_update  = frame_pop && !delta_mode;
    assign stat.last_total    = last_total_reg;

endmodule

/* hdl/meter_frame_receiver.sv */
// Result path: the checksum word of a good frame writes the frame into the queue;
// it then loads the output register once that register is free or being taken.
// Throughput: one input word per cycle; a frame is 23 words and yields at most
// one result word. Input stalls only on the checksum word while the queue is full.
// Reset: synchronous, active low; it clears the frame hunter, the queue, the
// output valid flag, the 32-bit running total and both configuration registers.
// ----------------------------------------------------------------------------
// meter_frame_receiver: serial frame parser of an energy metering chip
// Collects 23-word frames that start with the header 0x55, checks the
// inverted additive checksum and emits the measurement fields of each good
// frame, with the pulse count optionally extended to a 32-bit total.
// ----------------------------------------------------------------------------
module meter_frame_receiver #(
    parameter int QueueDepth = mfr_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream. s_tdata: rx_byte [7:0].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    // Result stream. m_tdata from bit 0 up: current_rms [23:0],
    // voltage_rms [47:24], fast_current_rms [71:48], active_power [95:72],
    // energy_count [127:96], freq_period [143:128], status_byte [151:144].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mfr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration write channel. Index 0: device_address, 1: delta_mode.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mfr_pkg::*;

    // Configuration registers. Writes are always taken; an unknown index is
    // ignored and only the low bits that fit each register are kept.
    logic [1:0] device_address_reg;
    logic       delta_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= '0;
            delta_mode_reg     <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: device_address_reg <= cfg_data[1:0];
                REG_DELTA_MODE:     delta_mode_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // The front end hunts for headers and validates frames; every good frame
    // goes into the queue as one record. The back end drains the queue into
    // the output register; a stalled result blocks intake only via a full queue.
    mfr_frame_t      front_rec;
    mfr_frame_t      queue_rec;
    logic            front_push;
    logic            back_pop;
    mfr_queue_stat_t queue_stat;
    mfr_back_stat_t  back_stat;

    mfr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_valid     (s_tvalid),
        .byte_ready     (s_tready),
        .rx_byte        (s_tdata),
        .device_address (device_address_reg),
        .queue_full     (queue_stat.full),
        .frame_push     (front_push),
        .frame_rec      (front_rec)
    );

    mfr_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_rec),
        .pop       (back_pop),
        .pop_data  (queue_rec),
        .stat      (queue_stat)
    );

    mfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_stat.empty),
        .frame_rec   (queue_rec),
        .frame_pop   (back_pop),
        .delta_mode  (delta_mode_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .stat        (back_stat)
    );

    // A good frame must never be lost to a full queue.
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        front_push |-> !queue_stat.full)
        else $error("frame pushed into a full queue");

    // Every push request of the front end is written into the queue.
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        front_push |-> queue_stat.push)
        else $error("frame push dropped by the queue");

    // Input back-pressure comes only from a full queue.
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> queue_stat.full)
        else $error("input stalled while the queue has room");

    // The running total moves only when a frame leaves the queue in total mode.
    a_total_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !back_stat.total_update |=> $stable(back_stat.last_total))
        else $error("running total changed without a total-mode frame");

    // A frame is popped only when the output register is free or being taken.
    a_pop_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.pop |-> (!m_tvalid || m_tready))
        else $error("output word overwritten before it was taken");

endmodule

/* test/meter_frame_receiver_test.sv */
// ----------------------------------------------------------------------------
// meter_frame_receiver_test: self-checking bench of the meter frame receiver
// Feeds received serial words through the input stream, mirrors the frame
// hunter, the checksum and the 32-bit count extension in a predictor of its
// own, and compares every result word field by field with the oldest
// prediction. Both stream sides idle at random; the registers are changed
// only once every predicted result has come out, at times mid-frame.
// ----------------------------------------------------------------------------
module meter_frame_receiver_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mfr_pkg::*;

    localparam int RESET_CYCLES  = 10;
    // Extra wait once every predicted reading has come out.
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 580;
    localparam int WRAP_FRAMES   = 12;
    localparam int MAX_REPORTS   = 30;

    // Frame positions of the fields.
    localparam int POS_CURRENT   = 1;
    localparam int POS_VOLTAGE   = 4;
    localparam int POS_FAST      = 7;
    localparam int POS_POWER     = 10;
    localparam int POS_COUNT     = 13;
    localparam int POS_PERIOD    = 16;
    localparam int POS_STATUS    = 19;

    typedef logic [7:0] frame_body_t [BODY_LEN];

    typedef struct packed {
        logic [7:0]         status_byte;
        logic [15:0]        freq_period;
        logic [31:0]        energy_count;
        logic signed [23:0] active_power;
        logic [23:0]        fast_current_rms;
        logic [23:0]        voltage_rms;
        logic [23:0]        current_rms;
    } meter_reading_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    meter_frame_receiver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Predictor state: position in the frame (0 while hunting), the running
    // byte sum, the stored frame words, the extended total and the registers.
    int unsigned      hunt_pos = 0;
    logic [7:0]       frame_sum = '0;
    logic [7:0]       frame_words [BODY_LEN];
    logic [31:0]      running_total = '0;
    logic [1:0]       dev_addr = '0;
    logic             delta_on = 1'b0;

    meter_reading_t   pending_readings [$];
    int unsigned      fail_count = 0;
    int unsigned      words_taken = 0;
    // When set, neither side inserts idle cycles.
    bit               quiet = 1'b0;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] word24(int unsigned pos);
        return {frame_words[pos + 2], frame_words[pos + 1], frame_words[pos]};
    endfunction

    // Advances the predictor by one accepted word and queues the reading of
    // a frame whose checksum holds.
    function automatic void parse_word(logic [7:0] w);
        logic [7:0]     check;
        logic [31:0]    count;
        meter_reading_t r;
        words_taken++;
        if (hunt_pos == 0) begin
            if (w == HDR_BYTE) begin
                frame_words[0] = w;
                frame_sum = w;
                hunt_pos = 1;
            end
            return;
        end
        if (hunt_pos < BODY_LEN) begin
            frame_words[hunt_pos] = w;
            frame_sum = frame_sum + w;
            hunt_pos++;
            return;
        end
        // Checksum word: the seed takes the address as it is right now.
        hunt_pos = 0;
        check = ~((RD_CMD | {6'b0, dev_addr}) + frame_sum);
        frame_sum = '0;
        if (check != w)
            return;
        if (delta_on) begin
            count = {8'b0, word24(POS_COUNT)};
        end else begin
            count = (running_total & CNT_HIGH_MASK) | {8'b0, word24(POS_COUNT)};
            if (count < running_total)
                count = count + CNT_WRAP_STEP;
            running_total = count;
        end
        r.current_rms      = word24(POS_CURRENT);
        r.voltage_rms      = word24(POS_VOLTAGE);
        r.fast_current_rms = word24(POS_FAST);
        r.active_power     = word24(POS_POWER);
        r.energy_count     = count;
        r.freq_period      = {frame_words[POS_PERIOD + 1], frame_words[POS_PERIOD]};
        r.status_byte      = frame_words[POS_STATUS];
        pending_readings.push_back(r);
    endfunction

    // Checksum word that the block accepts with the current address.
    function automatic logic [7:0] frame_check(frame_body_t body);
        logic [7:0] sum;
        sum = RD_CMD | {6'b0, dev_addr};
        foreach (body[i])
            sum = sum + body[i];
        return ~sum;
    endfunction

    // Random frame content, with frequent all-zero, all-one and header words.
    function automatic frame_body_t random_body();
        frame_body_t body;
        body[0] = HDR_BYTE;
        for (int i = 1; i < BODY_LEN; i++) begin
            case ($urandom_range(0, 9))
                0: body[i] = 8'h00;
                1: body[i] = 8'hFF;
                2: body[i] = HDR_BYTE;
                default: body[i] = 8'($urandom);
            endcase
        end
        return body;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_word(input logic [7:0] w);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        parse_word(w);
    endtask

    // Sends a whole frame; with spoil set, its checksum is changed so it fails.
    task automatic send_frame(input frame_body_t body, input bit spoil);
        logic [7:0] check;
        foreach (body[i])
            send_word(body[i]);
        check = frame_check(body);
        if (spoil)
            check[$urandom_range(0, 7)] = ~check[$urandom_range(0, 7)] | 1'b0;
        if (spoil && check == frame_check(body))
            check = ~check;
        send_word(check);
    endtask

    // Completes whatever frame the block is in, so the next header starts one.
    task automatic sync_to_hunt();
        while (hunt_pos != 0)
            send_word(8'($urandom));
    endtask

    // Waits until every reading has come out and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow one another back to back.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DEVICE_ADDRESS: dev_addr = val[1:0];
            REG_DELTA_MODE:     delta_on = val[0];
            default: ;
        endcase
    endtask

    // Writes both registers with random unused upper bits; a stray write to
    // an index past the register list may go in between.
    task automatic apply_settings(input logic [1:0] addr, input logic delta, input bit stray);
        settle();
        write_register(REG_DEVICE_ADDRESS, {6'($urandom), addr});
        if (stray)
            write_register(CFG_INDEX_W'($urandom_range(int'(REG_DELTA_MODE) + 1,
                                                       (1 << CFG_INDEX_W) - 1)),
                           8'($urandom));
        write_register(REG_DELTA_MODE, {7'($urandom), delta});
        cfg_valid <= 1'b0;
    endtask

    // Runs with the reset register values: all-zero and all-one frames, a
    // count that drops back to zero, and both ends of the signed power.
    task automatic test_field_extremes();
        frame_body_t body;
        body[0] = HDR_BYTE;
        for (int i = 1; i < BODY_LEN; i++)
            body[i] = 8'h00;
        send_frame(body, 1'b0);
        for (int i = 1; i < BODY_LEN; i++)
            body[i] = 8'hFF;
        send_frame(body, 1'b0);
        for (int i = 1; i < BODY_LEN; i++)
            body[i] = 8'h00;
        send_frame(body, 1'b0);
        body = random_body();
        {body[POS_POWER + 2], body[POS_POWER + 1], body[POS_POWER]} = 24'h80_0000;
        send_frame(body, 1'b0);
        body = random_body();
        {body[POS_POWER + 2], body[POS_POWER + 1], body[POS_POWER]} = 24'h7F_FFFF;
        send_frame(body, 1'b0);
    endtask

    // Words other than the header are dropped while hunting; a header word
    // inside a frame is plain data.
    task automatic test_garbage_hunt();
        frame_body_t body;
        send_word(8'h00);
        send_word(8'hFF);
        send_word(HDR_BYTE - 8'd1);
        send_word(HDR_BYTE + 8'd1);
        send_word(~HDR_BYTE);
        for (int i = 0; i < BODY_LEN; i++)
            body[i] = HDR_BYTE;
        send_frame(body, 1'b0);
    endtask

    // A frame with a broken checksum must vanish and leave the total alone.
    task automatic test_bad_checksum();
        send_frame(random_body(), 1'b1);
        send_frame(random_body(), 1'b0);
        send_frame(random_body(), 1'b1);
        send_frame(random_body(), 1'b1);
        send_frame(random_body(), 1'b0);
    endtask

    // Every address in both count modes, then back to total mode, which
    // resumes from the total held through delta mode.
    task automatic test_register_settings();
        for (int k = 0; k < 8; k++) begin
            apply_settings(2'(k), 1'(k >> 2), (k % 3) == 0);
            send_frame(random_body(), 1'b0);
            send_frame(random_body(), 1'b0);
        end
        apply_settings(2'b00, 1'b0, 1'b1);
        send_frame(random_body(), 1'b0);
    endtask

    // The address changes between the body and the checksum word of a frame;
    // the checksum must be judged with the new address.
    task automatic test_seed_timing();
        frame_body_t body;
        body = random_body();
        foreach (body[i])
            send_word(body[i]);
        apply_settings(dev_addr + 2'd1, delta_on, 1'b0);
        send_word(frame_check(body));
        send_frame(random_body(), 1'b0);
    endtask

    // Falling raw counts push the total up one step per frame, so the
    // upper byte of the total keeps carrying.
    task automatic test_count_wrap();
        frame_body_t body;
        apply_settings(dev_addr, 1'b0, 1'b0);
        quiet = 1'b1;
        for (int k = 0; k < WRAP_FRAMES; k++) begin
            body = random_body();
            body[POS_COUNT + 2] = ~8'(k);
            send_frame(body, 1'b0);
        end
        quiet = 1'b0;
    endtask

    // Mostly well-formed frames with random content, some with bad checksums,
    // some cut short, and loose noise between them.
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned frames;
        int unsigned cut;
        goal = words_taken + RANDOM_WORDS;
        frames = 0;
        while (words_taken < goal) begin
            frames++;
            if (frames % 12 == 0) begin
                apply_settings(2'($urandom), 1'($urandom_range(0, 2) == 0),
                               $urandom_range(0, 3) == 0);
                quiet = $urandom_range(0, 4) == 0;
            end
            case ($urandom_range(0, 9))
                0: begin
                    sync_to_hunt();
                    send_frame(random_body(), 1'b1);
                end
                1: begin
                    // A frame broken off part way; the next words fill it up.
                    cut = $urandom_range(1, BODY_LEN - 1);
                    send_word(HDR_BYTE);
                    repeat (cut) send_word(8'($urandom));
                end
                2: begin
                    repeat ($urandom_range(1, 8)) send_word(8'($urandom));
                end
                default: begin
                    sync_to_hunt();
                    send_frame(random_body(), 1'b0);
                end
            endcase
        end
        quiet = 1'b0;
    endtask

    // Receiver side: random stretches of stall between runs of ready.
    initial begin
        int unsigned gap;
        @(posedge aclk);
        forever begin
            gap = idle_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Every accepted result word is held against the oldest prediction.
    meter_reading_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: result word with no reading expected, actual %0h",
                             $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("current_rms", want.current_rms, m_tdata[23:0]);
                check_field("voltage_rms", want.voltage_rms, m_tdata[47:24]);
                check_field("fast_current_rms", want.fast_current_rms, m_tdata[71:48]);
                check_field("active_power", 32'(unsigned'(want.active_power)),
                            m_tdata[95:72]);
                check_field("energy_count", want.energy_count, m_tdata[127:96]);
                check_field("freq_period", want.freq_period, m_tdata[143:128]);
                check_field("status_byte", want.status_byte, m_tdata[151:144]);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_garbage_hunt();
        test_bad_checksum();
        test_register_settings();
        test_seed_timing();
        test_count_wrap();
        test_random_traffic();
        settle();
        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* meter_frame_receiver.f */
hdl/mfr_pkg.sv
hdl/mfr_front.sv
hdl/mfr_queue.sv
hdl/mfr_back.sv
hdl/meter_frame_receiver.sv
test/meter_frame_receiver_test.sv
